/* design/psos_pkg.sv */
// Shared types and constants of the PostScript operand stack.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package psos_pkg;

	localparam int CMD_W    = 4;
	localparam int TAG_W    = 2;
	localparam int STAT_W   = 3;
	localparam int DOUT_W   = 9;
	localparam int IVAL_W   = 32;

	localparam logic [TAG_W-1:0] TAG_INT   = 2'd0;
	localparam logic [TAG_W-1:0] TAG_MARK  = 2'd1;
	localparam logic [TAG_W-1:0] TAG_OTHER = 2'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 4'd0,
		CMD_CLEAR  = 4'd1,
		CMD_CTMARK = 4'd2,
		CMD_COUNT  = 4'd3,
		CMD_CNTTM  = 4'd4,
		CMD_DUP    = 4'd5,
		CMD_EXCH   = 4'd6,
		CMD_INDEX  = 4'd7,
		CMD_MARK   = 4'd8,
		CMD_POP    = 4'd9,
		CMD_ROLL   = 4'd10
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_RANGE     = 3'd3,
		ST_TYPE      = 3'd4,
		ST_UNMATCHED = 3'd5
	} status_t;

	// datapath micro-operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PUSH,
		OP_PUSH_MARK,
		OP_PUSH_CNT,
		OP_PUSH_CTM,
		OP_PUSH_A,
		OP_WR_TOP_B,
		OP_WR_SEC_A,
		OP_WR_LO_B,
		OP_WR_HI_A,
		OP_CLEAR,
		OP_POP,
		OP_CTM_INIT,
		OP_SCAN_NEXT,
		OP_CTM_DROP,
		OP_IDX_PTR,
		OP_ROLL_INIT,
		OP_DIV_STEP,
		OP_DIV_FIX,
		OP_REV1,
		OP_REV2,
		OP_REV3,
		OP_RESULT
	} op_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_TOP,
		RD_SEC,
		RD_LO,
		RD_HI
	} rd_sel_t;

	typedef enum logic [1:0] {
		CAP_NONE,
		CAP_A,
		CAP_B
	} cap_sel_t;

	typedef enum logic [1:0] {
		PH_ALL,
		PH_LOW,
		PH_HIGH
	} phase_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DEC,
		S_SCAN_RD,
		S_SCAN_CK,
		S_DUP_CAP,
		S_DUP_WR,
		S_EX_A,
		S_EX_B,
		S_EX_W1,
		S_EX_W2,
		S_IX_A,
		S_IX_CK,
		S_IX_RD,
		S_IX_B,
		S_IX_W,
		S_RL_B,
		S_RL_A,
		S_RL_CK,
		S_DIV,
		S_RL_GO,
		S_SW_CHK,
		S_SW_A,
		S_SW_B,
		S_SW_W1,
		S_SW_W2,
		S_RES,
		S_RES_OUT,
		S_OUT
	} state_t;

	typedef struct packed {
		op_t      op;
		rd_sel_t  rd;
		cap_sel_t cap;
		logic     st_we;
		status_t  st;
	} dp_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic d_zero;
		logic d_lt2;
		logic d_full;
		logic ptag_bad;
		logic rd_mark;
		logic lo_zero;
		logic a_int;
		logic b_int;
		logic idx_bad;
		logic roll_bad;
		logic n_le1;
		logic div_done;
		logic rem_zero;
		logic lo_lt_hi;
	} dp_flags_t;

endpackage
`default_nettype wire

/* design/psos_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module psos_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* design/psos_ctrl.sv */
// Command sequencer of the operand stack: a single state machine steps through every command.
// Depends on psos_pkg; drives psos_dp through dp_ctl_t.
`timescale 1ns / 1ps
`default_nettype none
module psos_ctrl import psos_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire dp_flags_t flags,
	output dp_ctl_t        ctl
);

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_ALL;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		ctl       = '{op: OP_NONE, rd: RD_NONE, cap: CAP_NONE, st_we: 1'b0, st: ST_OK};
		state_d   = state_q;
		phase_d   = phase_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.op  = OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_RES;
				unique case (flags.cmd)
					CMD_PUSH: begin
						if (flags.ptag_bad) begin
							ctl.st_we = 1'b1; ctl.st = ST_TYPE;
						end else if (flags.d_full) begin
							ctl.st_we = 1'b1; ctl.st = ST_OVERFLOW;
						end else begin
							ctl.op = OP_PUSH;
						end
					end
					CMD_CLEAR: ctl.op = OP_CLEAR;
					CMD_CTMARK, CMD_CNTTM: begin
						if (flags.d_zero) begin
							ctl.st_we = 1'b1; ctl.st = ST_UNMATCHED;
						end else begin
							ctl.op  = OP_CTM_INIT;
							state_d = S_SCAN_RD;
						end
					end
					CMD_COUNT: begin
						if (flags.d_full) begin
							ctl.st_we = 1'b1; ctl.st = ST_OVERFLOW;
						end else begin
							ctl.op = OP_PUSH_CNT;
						end
					end
					CMD_DUP: begin
						if (flags.d_zero) begin
							ctl.st_we = 1'b1; ctl.st = ST_UNDERFLOW;
						end else if (flags.d_full) begin
							ctl.st_we = 1'b1; ctl.st = ST_OVERFLOW;
						end else begin
							ctl.rd  = RD_TOP;
							state_d = S_DUP_CAP;
						end
					end
					CMD_EXCH: begin
						if (flags.d_lt2) begin
							ctl.st_we = 1'b1; ctl.st = ST_UNDERFLOW;
						end else begin
							ctl.rd  = RD_TOP;
							state_d = S_EX_A;
						end
					end
					CMD_INDEX: begin
						if (flags.d_zero) begin
							ctl.st_we = 1'b1; ctl.st = ST_UNDERFLOW;
						end else begin
							ctl.rd  = RD_TOP;
							state_d = S_IX_A;
						end
					end
					CMD_MARK: begin
						if (flags.d_full) begin
							ctl.st_we = 1'b1; ctl.st = ST_OVERFLOW;
						end else begin
							ctl.op = OP_PUSH_MARK;
						end
					end
					CMD_POP: begin
						if (flags.d_zero) begin
							ctl.st_we = 1'b1; ctl.st = ST_UNDERFLOW;
						end else begin
							ctl.op = OP_POP;
						end
					end
					CMD_ROLL: begin
						if (flags.d_lt2) begin
							ctl.st_we = 1'b1; ctl.st = ST_UNDERFLOW;
						end else begin
							ctl.rd  = RD_SEC;
							state_d = S_RL_B;
						end
					end
					default: state_d = S_RES;
				endcase
			end
			S_SCAN_RD: begin
				ctl.rd  = RD_LO;
				state_d = S_SCAN_CK;
			end
			S_SCAN_CK: begin
				if (flags.rd_mark) begin
					state_d = S_RES;
					if (flags.cmd == CMD_CTMARK) begin
						ctl.op = OP_CTM_DROP;
					end else if (flags.d_full) begin
						ctl.st_we = 1'b1; ctl.st = ST_OVERFLOW;
					end else begin
						ctl.op = OP_PUSH_CTM;
					end
				end else if (flags.lo_zero) begin
					ctl.st_we = 1'b1; ctl.st = ST_UNMATCHED;
					state_d = S_RES;
				end else begin
					ctl.op  = OP_SCAN_NEXT;
					state_d = S_SCAN_RD;
				end
			end
			S_DUP_CAP: begin
				ctl.cap = CAP_A;
				state_d = S_DUP_WR;
			end
			S_DUP_WR: begin
				ctl.op  = OP_PUSH_A;
				state_d = S_RES;
			end
			S_EX_A: begin
				ctl.cap = CAP_A;
				ctl.rd  = RD_SEC;
				state_d = S_EX_B;
			end
			S_EX_B: begin
				ctl.cap = CAP_B;
				state_d = S_EX_W1;
			end
			S_EX_W1: begin
				ctl.op  = OP_WR_TOP_B;
				state_d = S_EX_W2;
			end
			S_EX_W2: begin
				ctl.op  = OP_WR_SEC_A;
				state_d = S_RES;
			end
			S_IX_A: begin
				ctl.cap = CAP_A;
				state_d = S_IX_CK;
			end
			S_IX_CK: begin
				if (!flags.a_int) begin
					ctl.st_we = 1'b1; ctl.st = ST_TYPE;
					state_d = S_RES;
				end else if (flags.idx_bad) begin
					ctl.st_we = 1'b1; ctl.st = ST_RANGE;
					state_d = S_RES;
				end else begin
					ctl.op  = OP_IDX_PTR;
					state_d = S_IX_RD;
				end
			end
			S_IX_RD: begin
				ctl.rd  = RD_LO;
				state_d = S_IX_B;
			end
			S_IX_B: begin
				ctl.cap = CAP_B;
				state_d = S_IX_W;
			end
			S_IX_W: begin
				ctl.op  = OP_WR_TOP_B;
				state_d = S_RES;
			end
			S_RL_B: begin
				ctl.cap = CAP_B;
				ctl.rd  = RD_TOP;
				state_d = S_RL_A;
			end
			S_RL_A: begin
				ctl.cap = CAP_A;
				state_d = S_RL_CK;
			end
			S_RL_CK: begin
				if (!flags.b_int || !flags.a_int) begin
					ctl.st_we = 1'b1; ctl.st = ST_TYPE;
					state_d = S_RES;
				end else if (flags.roll_bad) begin
					ctl.st_we = 1'b1; ctl.st = ST_RANGE;
					state_d = S_RES;
				end else begin
					// init also drops the two operands
					ctl.op  = OP_ROLL_INIT;
					state_d = flags.n_le1 ? S_RES : S_DIV;
				end
			end
			S_DIV: begin
				if (flags.div_done) begin
					ctl.op  = OP_DIV_FIX;
					state_d = S_RL_GO;
				end else begin
					ctl.op = OP_DIV_STEP;
				end
			end
			S_RL_GO: begin
				if (flags.rem_zero) begin
					state_d = S_RES;
				end else begin
					ctl.op  = OP_REV1;
					phase_d = PH_ALL;
					state_d = S_SW_CHK;
				end
			end
			S_SW_CHK: begin
				if (flags.lo_lt_hi) begin
					ctl.rd  = RD_LO;
					state_d = S_SW_A;
				end else begin
					unique case (phase_q)
						PH_ALL: begin
							ctl.op  = OP_REV2;
							phase_d = PH_LOW;
						end
						PH_LOW: begin
							ctl.op  = OP_REV3;
							phase_d = PH_HIGH;
						end
						PH_HIGH: state_d = S_RES;
						default: state_d = S_RES;
					endcase
				end
			end
			S_SW_A: begin
				ctl.cap = CAP_A;
				ctl.rd  = RD_HI;
				state_d = S_SW_B;
			end
			S_SW_B: begin
				ctl.cap = CAP_B;
				state_d = S_SW_W1;
			end
			S_SW_W1: begin
				ctl.op  = OP_WR_LO_B;
				state_d = S_SW_W2;
			end
			S_SW_W2: begin
				ctl.op  = OP_WR_HI_A;
				state_d = S_SW_CHK;
			end
			S_RES: begin
				ctl.rd  = RD_TOP;
				state_d = S_RES_OUT;
			end
			S_RES_OUT: begin
				ctl.op  = OP_RESULT;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* design/psos_dp.sv */
// Datapath of the operand stack: stack RAM, depth, pointers, remainder unit.
// Depends on psos_pkg and psos_ram; commanded by psos_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module psos_dp import psos_pkg::*; #(
	parameter int STACK_DEPTH = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dp_ctl_t                  ctl,
	output dp_flags_t                     flags,
	input  wire logic [CMD_W-1:0]         command,
	input  wire logic [TAG_W-1:0]         push_tag,
	input  wire logic signed [IVAL_W-1:0] push_value,
	output logic [STAT_W-1:0]             status,
	output logic [DOUT_W-1:0]             depth_after,
	output logic [TAG_W-1:0]              top_tag,
	output logic signed [IVAL_W-1:0]      top_value
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int EW = TAG_W + VALUE_WIDTH;
	localparam int BW = $clog2(VALUE_WIDTH + 1);
	localparam int CW = ((VALUE_WIDTH > DW) ? VALUE_WIDTH : DW) + 1;

	logic [CMD_W-1:0]             cmd_q;
	logic [TAG_W-1:0]             ptag_q;
	logic signed [VALUE_WIDTH-1:0] pval_q;
	logic [DW-1:0]                depth_q;
	logic [EW-1:0]                a_q, b_q;
	logic [AW-1:0]                lo_q, hi_q;
	logic [DW-1:0]                cnt_q, rem_q;
	logic [VALUE_WIDTH-1:0]       dvd_q;
	logic [BW-1:0]                bit_q;
	logic                         jneg_q;
	status_t                      st_q;
	logic [STAT_W-1:0]            res_status_q;
	logic [DOUT_W-1:0]            res_depth_q;
	logic [TAG_W-1:0]             res_tag_q;
	logic signed [IVAL_W-1:0]     res_value_q;

	logic                   ram_we, ram_re;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [EW-1:0]          ram_wdata, ram_rdata;

	logic [DW-1:0]          depth_m1, depth_m2, cnt_m1, base, base_rem;
	logic [TAG_W-1:0]       a_tag, b_tag, r_tag;
	logic [VALUE_WIDTH-1:0] a_val, b_val;
	logic signed [CW-1:0]   a_n, b_n, d_m1_s, d_m2_s;
	logic [DW:0]            div_t, div_sub;
	logic                   div_ge;
	logic [VALUE_WIDTH-1:0] j_abs;

	psos_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign depth_m1 = depth_q - DW'(1);
	assign depth_m2 = depth_q - DW'(2);
	assign cnt_m1   = cnt_q - DW'(1);
	assign base     = depth_q - cnt_q;
	assign base_rem = base + rem_q;

	assign a_tag = a_q[EW-1 -: TAG_W];
	assign b_tag = b_q[EW-1 -: TAG_W];
	assign r_tag = ram_rdata[EW-1 -: TAG_W];
	assign a_val = a_q[VALUE_WIDTH-1:0];
	assign b_val = b_q[VALUE_WIDTH-1:0];

	assign a_n    = CW'($signed(a_val));
	assign b_n    = CW'($signed(b_val));
	assign d_m1_s = $signed(CW'(depth_q)) - CW'(1);
	assign d_m2_s = $signed(CW'(depth_q)) - CW'(2);

	assign j_abs = a_val[VALUE_WIDTH-1] ? (~a_val + VALUE_WIDTH'(1)) : a_val;

	// one restoring step of |j| mod n
	assign div_t   = {rem_q, dvd_q[VALUE_WIDTH-1]};
	assign div_ge  = div_t >= {1'b0, cnt_q};
	assign div_sub = div_t - {1'b0, cnt_q};

	always_comb begin
		flags.cmd      = cmd_q;
		flags.d_zero   = depth_q == '0;
		flags.d_lt2    = depth_q < DW'(2);
		flags.d_full   = depth_q >= DW'(STACK_DEPTH);
		flags.ptag_bad = ptag_q > TAG_OTHER;
		flags.rd_mark  = r_tag == TAG_MARK;
		flags.lo_zero  = lo_q == '0;
		flags.a_int    = a_tag == TAG_INT;
		flags.b_int    = b_tag == TAG_INT;
		flags.idx_bad  = a_n < 0 || a_n >= d_m1_s;
		flags.roll_bad = b_n < 0 || b_n > d_m2_s;
		flags.n_le1    = b_n < CW'(2);
		flags.div_done = bit_q == '0;
		flags.rem_zero = rem_q == '0;
		flags.lo_lt_hi = lo_q < hi_q;
	end

	always_comb begin
		ram_re    = 1'b1;
		ram_raddr = '0;
		unique case (ctl.rd)
			RD_NONE: ram_re    = 1'b0;
			RD_TOP:  ram_raddr = depth_m1[AW-1:0];
			RD_SEC:  ram_raddr = depth_m2[AW-1:0];
			RD_LO:   ram_raddr = lo_q;
			RD_HI:   ram_raddr = hi_q;
			default: ram_re    = 1'b0;
		endcase
	end

	always_comb begin
		ram_we    = 1'b1;
		ram_waddr = depth_q[AW-1:0];
		ram_wdata = a_q;
		unique case (ctl.op)
			OP_PUSH:      ram_wdata = {ptag_q, (ptag_q == TAG_MARK) ? '0 : pval_q};
			OP_PUSH_MARK: ram_wdata = {TAG_MARK, {VALUE_WIDTH{1'b0}}};
			OP_PUSH_CNT:  ram_wdata = {TAG_INT, VALUE_WIDTH'(depth_q)};
			OP_PUSH_CTM:  ram_wdata = {TAG_INT, VALUE_WIDTH'(cnt_m1)};
			OP_PUSH_A:    ram_wdata = a_q;
			OP_WR_TOP_B: begin
				ram_waddr = depth_m1[AW-1:0];
				ram_wdata = b_q;
			end
			OP_WR_SEC_A:  ram_waddr = depth_m2[AW-1:0];
			OP_WR_LO_B: begin
				ram_waddr = lo_q;
				ram_wdata = b_q;
			end
			OP_WR_HI_A:   ram_waddr = hi_q;
			default:      ram_we    = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			st_q    <= ST_OK;
		end else begin
			if (ctl.st_we) begin
				st_q <= ctl.st;
			end
			unique case (ctl.op)
				OP_LOAD:     st_q    <= ST_OK;
				OP_PUSH, OP_PUSH_MARK, OP_PUSH_CNT, OP_PUSH_CTM, OP_PUSH_A:
					depth_q <= depth_q + DW'(1);
				OP_CLEAR:    depth_q <= '0;
				OP_POP:      depth_q <= depth_m1;
				OP_CTM_DROP: depth_q <= base;
				OP_ROLL_INIT: depth_q <= depth_m2;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.cap)
			CAP_A:   a_q <= ram_rdata;
			CAP_B:   b_q <= ram_rdata;
			default: ;
		endcase
		unique case (ctl.op)
			OP_LOAD: begin
				cmd_q  <= command;
				ptag_q <= push_tag;
				pval_q <= VALUE_WIDTH'(push_value);
			end
			OP_CTM_INIT: begin
				lo_q  <= depth_m1[AW-1:0];
				cnt_q <= DW'(1);
			end
			OP_SCAN_NEXT: begin
				lo_q  <= lo_q - AW'(1);
				cnt_q <= cnt_q + DW'(1);
			end
			OP_IDX_PTR: lo_q <= AW'(depth_m2 - DW'(a_val));
			OP_ROLL_INIT: begin
				cnt_q  <= DW'(b_val);
				rem_q  <= '0;
				dvd_q  <= j_abs;
				jneg_q <= a_val[VALUE_WIDTH-1];
				bit_q  <= BW'(VALUE_WIDTH);
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? div_sub[DW-1:0] : div_t[DW-1:0];
				dvd_q <= {dvd_q[VALUE_WIDTH-2:0], 1'b0};
				bit_q <= bit_q - BW'(1);
			end
			OP_DIV_FIX: begin
				if (jneg_q && rem_q != '0) begin
					rem_q <= cnt_q - rem_q;
				end
			end
			OP_REV1: begin
				lo_q <= base[AW-1:0];
				hi_q <= depth_m1[AW-1:0];
			end
			OP_REV2: begin
				lo_q <= base[AW-1:0];
				hi_q <= AW'(base_rem - DW'(1));
			end
			OP_REV3: begin
				lo_q <= base_rem[AW-1:0];
				hi_q <= depth_m1[AW-1:0];
			end
			OP_WR_HI_A: begin
				lo_q <= lo_q + AW'(1);
				hi_q <= hi_q - AW'(1);
			end
			OP_RESULT: begin
				res_status_q <= st_q;
				res_depth_q  <= DOUT_W'(depth_q);
				if (depth_q != '0) begin
					res_tag_q   <= r_tag;
					res_value_q <= IVAL_W'($signed(ram_rdata[VALUE_WIDTH-1:0]));
				end else begin
					res_tag_q   <= '0;
					res_value_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign status      = res_status_q;
	assign depth_after = res_depth_q;
	assign top_tag     = res_tag_q;
	assign top_value   = res_value_q;

endmodule
`default_nettype wire

/* design/postscript_operand_stack_core.sv */
// Operand stack core: one command per transfer, one result per command.
// Each command is loaded and decoded; the top entry is then read and registered.
// dup, exch and index add operand reads and writes; (count/clear)tomark scans entry by
// entry; roll with n > 1 adds operand reads, a one-bit-per-cycle remainder, ~n swaps.
// Throughput: one command at a time; next input taken the cycle after the result transfer.
// Reset (arst_n low) empties the stack; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module postscript_operand_stack_core import psos_pkg::*; #(
	parameter int STACK_DEPTH = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [CMD_W-1:0]         command,
	input  wire logic [TAG_W-1:0]         push_tag,
	input  wire logic signed [IVAL_W-1:0] push_value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [STAT_W-1:0]             status,
	output logic [DOUT_W-1:0]             depth_after,
	output logic [TAG_W-1:0]              top_tag,
	output logic signed [IVAL_W-1:0]      top_value
);

	// controller sequences RAM reads/writes; datapath holds all stack state
	dp_ctl_t   ctl;
	dp_flags_t flags;

	psos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.ctl       (ctl)
	);

	// roll runs as remainder (one bit per cycle) then three in-place reversals unless it is zero
	psos_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.flags       (flags),
		.command     (command),
		.push_tag    (push_tag),
		.push_value  (push_value),
		.status      (status),
		.depth_after (depth_after),
		.top_tag     (top_tag),
		.top_value   (top_value)
	);

endmodule
`default_nettype wire
